// ===== src/orb_pkg.sv =====
// orb_pkg: shared types and constants of the radiation boundary block
// no dependencies
`timescale 1ns / 1ps
package orb_pkg;
   localparam int CELLS = 1024;
   localparam int IDX_W = 10;
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   typedef struct packed {
      logic [9:0]         cell_index;
      logic signed [31:0] inner1_now;
      logic signed [31:0] inner2_now;
      logic signed [31:0] inner1_next;
      logic signed [31:0] edge_prev;
      logic signed [31:0] inner1_prev;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] edge_value;
      logic [16:0]        phase_speed;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_SPEED, ST_DIV1, ST_BLEND1, ST_BLEND2,
      ST_NUM1, ST_NUM2, ST_DIV2, ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic load;
      logic read;
      logic speed;
      logic div1_start;
      logic blend1;
      logic blend2;
      logic num1;
      logic num2;
      logic div2_start;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic div_done;
      logic need_div1;
   } sts_type;

   localparam logic [0:0] REG_SMOOTHING = 1'b0;
endpackage

// ===== src/orb_div.sv =====
// orb_div: unsigned restoring divider, one quotient bit per cycle, 64 / 64
// depends on orb_pkg only by convention (no imports)
`timescale 1ns / 1ps
module orb_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;

   // shift one bit and try a subtract
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]} - {1'b0, dsr_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== src/orb_datapath.sv =====
// orb_datapath: speed store, blend multipliers, shared divider, result register
// depends on orb_pkg and orb_div
`timescale 1ns / 1ps
module orb_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  orb_pkg::cmd_type      cmd,
   output orb_pkg::sts_type      sts,
   input  orb_pkg::req_word_type req_word,
   input  logic [16:0]           smoothing,
   output orb_pkg::rsp_word_type rsp_word
);
   logic [16:0] store [orb_pkg::CELLS];
   orb_pkg::req_word_type item_ff;
   logic [9:0]  clr_ff;
   logic        clr_done_ff;
   logic [16:0] old_ff, sf_ff, raw_ff, c_ff;
   logic signed [33:0] num_ff, den_ff;
   logic        need_div_ff, neg_ff;
   logic signed [49:0] p1_ff, p2_ff;
   logic        div_start;
   logic [63:0] div_a, div_b, div_q;
   logic        div_done;
   orb_pkg::rsp_word_type out_ff;
   logic signed [33:0] num_w, den_w;
   logic [16:0] sf_sat, old_sat;
   logic signed [65:0] numer;
   logic [65:0] mnumer;
   logic [63:0] q_lim;
   logic signed [33:0] q_s;

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + 10'd1;
         if (clr_ff == 10'(orb_pkg::CELLS - 1)) clr_done_ff <= 1'b1;
      end
   end

   // store port: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) store[clr_ff] <= '0;
      else if (cmd.num1) store[item_ff.cell_index] <= c_ff;
      if (cmd.read) old_ff <= store[item_ff.cell_index];
   end

   assign num_w  = 34'(item_ff.inner1_prev) - 34'(item_ff.inner1_next);
   assign den_w  = 34'(item_ff.inner1_next) + 34'(item_ff.inner1_prev)
                 - (34'(item_ff.inner2_now) <<< 1);
   assign sf_sat = (smoothing > orb_pkg::ONE_Q16) ? orb_pkg::ONE_Q16 : smoothing;
   assign old_sat = (old_ff > orb_pkg::ONE_Q16) ? orb_pkg::ONE_Q16 : old_ff;
   assign numer  = 66'(p1_ff) + 66'(p2_ff);
   assign mnumer = numer[65] ? 66'(-numer) : numer;
   assign q_lim  = div_q;
   assign q_s    = neg_ff ? -34'(q_lim[33:0]) : 34'(q_lim[33:0]);

   // item datapath
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_word;
         sf_ff   <= sf_sat;
      end
      if (cmd.speed) begin
         num_ff <= num_w;
         den_ff <= den_w;
         if (den_w == '0) begin
            raw_ff      <= orb_pkg::ONE_Q16;
            need_div_ff <= 1'b0;
         end else if (num_w == '0 || (num_w[33] != den_w[33])) begin
            raw_ff      <= '0;
            need_div_ff <= 1'b0;
         end else need_div_ff <= 1'b1;
      end
      if (cmd.div1_start == 1'b0 && div_done && need_div_ff && !cmd.num2
          && !cmd.div2_start && cmd.blend1 == 1'b0) begin
         raw_ff <= (div_q > 64'(orb_pkg::ONE_Q16)) ? orb_pkg::ONE_Q16 : div_q[16:0];
         need_div_ff <= 1'b0;
      end
      if (cmd.blend1) begin
         p1_ff <= 50'(34'(sf_ff) * 34'(old_sat));
         p2_ff <= 50'(34'(orb_pkg::ONE_Q16 - sf_ff) * 34'(raw_ff));
      end
      if (cmd.blend2) c_ff <= 17'((34'(p1_ff) + 34'(p2_ff)) >> 16);
      if (cmd.num1) begin
         p1_ff <= 50'(item_ff.edge_prev) * 50'(signed'({1'b0, orb_pkg::ONE_Q16 - c_ff}));
         p2_ff <= 50'(item_ff.inner1_now) * 50'(signed'({1'b0, c_ff, 1'b0}));
      end
      if (cmd.num2) neg_ff <= numer[65];
      if (cmd.out_load) begin
         if (q_lim > 64'h8000_0000 || (!neg_ff && q_lim == 64'h8000_0000))
            out_ff.edge_value <= neg_ff ? 32'sh8000_0000 : 32'sh7fff_ffff;
         else
            out_ff.edge_value <= q_s[31:0];
         out_ff.phase_speed <= c_ff;
      end
   end

   // shared divider operands
   always_comb begin
      div_start = cmd.div1_start | cmd.div2_start;
      if (cmd.div2_start) begin
         div_a = mnumer[63:0];
         div_b = {30'b0, 34'(orb_pkg::ONE_Q16) + 34'(c_ff)};
      end else begin
         div_a = {14'b0, (num_ff[33] ? 34'(-num_ff) : 34'(num_ff)), 16'b0};
         div_b = {30'b0, (den_ff[33] ? 34'(-den_ff) : 34'(den_ff))};
      end
   end

   orb_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
   );

   assign sts.clear_done = clr_done_ff;
   assign sts.div_done   = div_done;
   assign sts.need_div1  = need_div_ff;
   assign rsp_word       = out_ff;
endmodule

// ===== src/orb_ctrl.sv =====
// orb_ctrl: sequencer for clear sweep, store read, up to two divisions and result
// depends on orb_pkg
`timescale 1ns / 1ps
module orb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  orb_pkg::sts_type sts,
   output orb_pkg::cmd_type cmd
);
   orb_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= orb_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff;
      req_stall    = 1'b1;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         orb_pkg::ST_CLEAR: begin
            cmd.clear_wr = !sts.clear_done;
            if (sts.clear_done) state_in = orb_pkg::ST_IDLE;
         end
         orb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = orb_pkg::ST_READ;
            end
         end
         orb_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = orb_pkg::ST_SPEED;
         end
         orb_pkg::ST_SPEED: begin
            cmd.speed = 1'b1;
            state_in  = orb_pkg::ST_DIV1;
         end
         orb_pkg::ST_DIV1: begin
            if (sts.need_div1) begin
               cmd.div1_start = 1'b1;
               state_in = orb_pkg::ST_BLEND1;
            end else state_in = orb_pkg::ST_BLEND1;
         end
         orb_pkg::ST_BLEND1: begin
            if (!sts.need_div1) begin
               cmd.blend1 = 1'b1;
               state_in = orb_pkg::ST_BLEND2;
            end
         end
         orb_pkg::ST_BLEND2: begin
            cmd.blend2 = 1'b1;
            state_in   = orb_pkg::ST_NUM1;
         end
         orb_pkg::ST_NUM1: begin
            cmd.num1 = 1'b1;
            state_in = orb_pkg::ST_NUM2;
         end
         orb_pkg::ST_NUM2: begin
            cmd.num2 = 1'b1;
            cmd.div2_start = 1'b1;
            state_in = orb_pkg::ST_DIV2;
         end
         orb_pkg::ST_DIV2: begin
            if (sts.div_done) state_in = orb_pkg::ST_OUT;
         end
         orb_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = orb_pkg::ST_IDLE;
            end
         end
         default: state_in = orb_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== src/orlanski_radiation_boundary.sv =====
// Orlanski radiation boundary: one word in, one word out. After reset the
// 1024-entry speed store is swept to zero, during which no word is accepted.
// Each word makes up to two passes through a shared 64-step one-bit-per-cycle
// divider (phase speed ratio, skipped when no division is needed, and the new
// edge value) and also takes a store read and multiplies.
// The result register lets the next word in while the last result waits.
// depends on orb_pkg, orb_ctrl, orb_datapath, orb_div
`timescale 1ns / 1ps
module orlanski_radiation_boundary (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  orb_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output orb_pkg::rsp_word_type rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [1:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   orb_pkg::cmd_type cmd;
   orb_pkg::sts_type sts;
   logic [16:0] smooth_ff;

   // smoothing factor register
   always_ff @(posedge clock) begin
      if (reset) smooth_ff <= '0;
      else if (csr_psel && csr_penable && csr_pwrite
               && csr_paddr[1:1] == orb_pkg::REG_SMOOTHING)
         smooth_ff <= csr_pwdata[16:0];
   end
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:1] == orb_pkg::REG_SMOOTHING)
                     ? {15'b0, smooth_ff} : 32'b0;

   orb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   orb_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .req_word(req_word),
      .smoothing(smooth_ff), .rsp_word(rsp_word)
   );

   // result speed never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.phase_speed <= orb_pkg::ONE_Q16)
      else $error("phase speed above one");
   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result changed under stall");
   // no word taken in the cycle after one was taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted too early");
endmodule

// ===== sim/tb_orlanski_radiation_boundary.sv =====
// testbench for orlanski_radiation_boundary: directed and random words checked
// against a behavioral predictor of the phase speed store and edge value
// depends on orb_pkg and the orlanski_radiation_boundary rtl
`timescale 1ns / 1ps
module tb_orlanski_radiation_boundary;

   // predictor of the boundary update and queue of expected words
   class edge_scoreboard;
      logic [16:0] speed_mem [orb_pkg::CELLS];
      logic [16:0] smoothing;
      orb_pkg::rsp_word_type pending_q[$];
      int errors;

      function void clear();
         foreach (speed_mem[i]) speed_mem[i] = '0;
         smoothing = '0;
         errors = 0;
      endfunction

      function void note_word(orb_pkg::req_word_type w);
         longint fi1, fi2, ffi1, fb, fbi1, num, den, numer, q;
         longint unsigned sf, old, cs, c, mn, md;
         orb_pkg::rsp_word_type r;
         fi1 = w.inner1_now;
         fi2 = w.inner2_now;
         ffi1 = w.inner1_next;
         fb = w.edge_prev;
         fbi1 = w.inner1_prev;
         sf = (smoothing > orb_pkg::ONE_Q16) ? 65536 : smoothing;
         old = speed_mem[w.cell_index];
         if (old > 65536) old = 65536;
         num = fbi1 - ffi1;
         den = ffi1 + fbi1 - 2 * fi2;
         if (den == 0) cs = 65536;
         else if (num == 0 || ((num < 0) != (den < 0))) cs = 0;
         else begin
            mn = (num < 0) ? -num : num;
            md = (den < 0) ? -den : den;
            cs = (mn << 16) / md;
            if (cs > 65536) cs = 65536;
         end
         c = (sf * old + (65536 - sf) * cs) >> 16;
         if (c > 65536) c = 65536;
         speed_mem[w.cell_index] = c[16:0];
         numer = fb * longint'(65536 - c) + 2 * longint'(c) * fi1;
         q = numer / longint'(65536 + c);
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         r.edge_value = q[31:0];
         r.phase_speed = c[16:0];
         pending_q.push_back(r);
      endfunction

      function void check_word(orb_pkg::rsp_word_type got);
         orb_pkg::rsp_word_type exp_w;
         if (pending_q.size() == 0) begin
            $error("unexpected result word %h", got);
            errors++;
            return;
         end
         exp_w = pending_q.pop_front();
         if (got.edge_value !== exp_w.edge_value) begin
            $error("edge_value expected %0d actual %0d", exp_w.edge_value, got.edge_value);
            errors++;
         end
         if (got.phase_speed !== exp_w.phase_speed) begin
            $error("phase_speed expected %0d actual %0d", exp_w.phase_speed,
               got.phase_speed);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   orb_pkg::req_word_type req_word;
   orb_pkg::rsp_word_type rsp_word;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   edge_scoreboard board;
   int send_idle_pct, recv_stall_pct;
   bit hold_off;

   orlanski_radiation_boundary DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver: random stall, long hold-off on request
   initial begin
      rsp_stall = 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off) rsp_stall <= 1'b1;
         else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // result checking at accepted words
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_word(rsp_word);
      end
   end

   task automatic write_smoothing(logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {orb_pkg::REG_SMOOTHING, 1'b0};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.smoothing = value[16:0];
   endtask

   // offer one word, with random idle gap before it
   task automatic send_word(orb_pkg::req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      board.note_word(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 8) << 16;
         3: return 32'($signed($urandom_range(0, 600000)) - 300000);
         default: return $urandom;
      endcase
   endfunction

   function automatic orb_pkg::req_word_type random_word();
      orb_pkg::req_word_type w;
      w.cell_index = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(15));
      w.inner1_now = pick_sample();
      w.inner2_now = pick_sample();
      w.inner1_next = pick_sample();
      w.edge_prev = pick_sample();
      w.inner1_prev = pick_sample();
      // equal neighbors give a zero denominator
      if ($urandom_range(15) == 0) begin
         w.inner1_next = w.inner2_now;
         w.inner1_prev = w.inner2_now;
      end
      return w;
   endfunction

   function automatic orb_pkg::req_word_type make_word(logic [9:0] idx, logic [31:0] a,
         logic [31:0] b, logic [31:0] nx, logic [31:0] ep, logic [31:0] pv);
      orb_pkg::req_word_type w;
      w.cell_index = idx;
      w.inner1_now = a;
      w.inner2_now = b;
      w.inner1_next = nx;
      w.edge_prev = ep;
      w.inner1_prev = pv;
      return w;
   endfunction

   // main sequence
   initial begin
      logic [31:0] smooth_set [5] = '{32'd0, 32'd65536, 32'd32768, 32'd131071, 32'd1000};
      int idle_set [4][2] = '{'{0, 0}, '{78, 0}, '{0, 78}, '{28, 28}};
      board = new();
      board.clear();
      hold_off = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: zero denominator, opposite signs, ratio below one, extremes
      write_smoothing(32'd0);
      send_word(make_word(10'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
         32'h0002_0000, 32'h0001_0000));
      send_word(make_word(10'd1, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0003_0000,
         32'h0003_0000));
      send_word(make_word(10'd2, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0001_0000,
         32'h0001_0000));
      send_word(make_word(10'd3, 32'h0004_0000, 32'h0, 32'h0001_0000, 32'h0001_0000,
         32'h0005_0000));
      send_word(make_word(10'd1023, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
         32'h7fff_ffff, 32'h8000_0000));
      send_word(make_word(10'd1023, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
         32'h8000_0000, 32'h7fff_ffff));
      send_word(make_word(10'd512, 32'h7fff_ffff, 32'h0, 32'h0, 32'h8000_0000, 32'h0));
      send_word(make_word(10'd512, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa,
         32'h7fff_ffff, 32'h0000_0001));
      drain();
      write_smoothing(32'd65536);
      send_word(make_word(10'd3, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0,
         32'h0002_0000));
      send_word(make_word(10'd0, 32'h8000_0000, 32'h0, 32'h0, 32'h7fff_ffff, 32'h0));
      drain();
      write_smoothing(32'd131071);
      send_word(make_word(10'd2, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0001_0000,
         32'h0001_0000));
      drain();

      // random phases over smoothing settings and idle patterns
      for (int p = 0; p < 20; p++) begin
         write_smoothing(smooth_set[p % 5]);
         send_idle_pct = idle_set[p % 4][0];
         recv_stall_pct = idle_set[p % 4][1];
         for (int n = 0; n < 42; n++) begin
            if (p == 5 && n == 2) begin
               fork
                  begin
                     hold_off = 1;
                     repeat (1500) @(posedge clock);
                     hold_off = 0;
                  end
               join_none
            end
            send_word(random_word());
         end
         drain();
      end

      if (board.errors == 0 && board.pending_q.size() == 0)
         $display("** orlanski_radiation_boundary: PASSED **");
      else
         $display("** orlanski_radiation_boundary: FAILED **");
      $finish;
   end

   initial begin
      #20ms;
      $display("** orlanski_radiation_boundary: FAILED **");
      $finish;
   end
endmodule

// ===== files.f =====
src/orb_pkg.sv
src/orb_div.sv
src/orb_datapath.sv
src/orb_ctrl.sv
src/orlanski_radiation_boundary.sv
sim/tb_orlanski_radiation_boundary.sv
